### rtl/cbdq_pkg.sv
// ============================================================================
// cbdq_pkg
// Shared types, constants and functions for the 3-bit codebook dequantizer.
// ============================================================================
package cbdq_pkg;

    localparam int GroupSize = 16;
    localparam int NumCodes  = 8;
    localparam int IdxW      = 3;
    localparam int LaneW     = 4;
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 16;

    localparam logic [15:0] CODE_RESET [NumCodes] = '{
        16'hBE0A, 16'hBDAB, 16'hBD3E, 16'hBC79,
        16'h3C79, 16'h3D3E, 16'h3DAB, 16'h3E0A
    };

    localparam logic [31:0] QNAN_F32 = 32'h7FC0_0000;
    localparam logic [31:0] INF_F32  = 32'h7F80_0000;

    typedef struct packed {
        logic [47:0] packed_indices;
        logic [31:0] scale_bits;
    } in_item_t;

    typedef struct packed {
        logic [31:0] value_bits;
        logic [3:0]  lane;
        logic        last;
    } out_item_t;

    // Operand classification for a bf16 value
    typedef struct packed {
        logic nan;
        logic inf;
        logic zero;
    } cls_t;

    function automatic cls_t bf16_class(input logic [15:0] v);
        cls_t c;
        c.nan  = (v[14:7] == 8'hFF) && (v[6:0] != 7'd0);
        c.inf  = (v[14:7] == 8'hFF) && (v[6:0] == 7'd0);
        c.zero = (v[14:7] == 8'd0);
        return c;
    endfunction

    // fp32 to bf16, round to nearest even, subnormals flushed
    function automatic logic [15:0] scale_to_bf16(input logic [31:0] f);
        logic [31:0] r;
        r = f + 32'h0000_7FFF + {31'd0, f[16]};
        if (f[30:23] == 8'hFF && f[22:0] != 23'd0)
            return f[31:16] | 16'h0040;
        else if (f[30:23] == 8'd0)
            return {f[31], 15'd0};
        else
            return r[31:16];
    endfunction

endpackage

### rtl/cbdq_issue.sv
// ============================================================================
// cbdq_issue
// Takes one group, holds it and sends one lane per cycle down the pipe.
// ============================================================================
module cbdq_issue
    import cbdq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  in_item_t          in_item,
    output logic              busy,
    output logic              lane_valid,
    output logic [IdxW-1:0]   lane_idx,
    output logic [LaneW-1:0]  lane_num,
    output logic              lane_last,
    output logic [15:0]       lane_scale
);

    logic              act_reg, act_next;
    logic [LaneW-1:0]  cnt_reg, cnt_next;
    logic [47:0]       idx_reg, idx_next;
    logic [15:0]       scale_reg, scale_next;
    logic              take;
    logic              at_last;

    // A new group may load while the final lane of the current one issues
    assign at_last = (cnt_reg == LaneW'(GroupSize - 1));
    assign busy    = act_reg && !at_last;
    assign take    = start && !busy;

    // Lane counter and index shifter
    always_comb
    begin
        act_next   = act_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        scale_next = scale_reg;
        if (take)
        begin
            act_next   = 1'b1;
            cnt_next   = '0;
            idx_next   = in_item.packed_indices;
            scale_next = scale_to_bf16(in_item.scale_bits);
        end
        else if (act_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            idx_next = idx_reg >> IdxW;
            if (at_last)
                act_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            act_reg <= act_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        scale_reg <= scale_next;
    end

    assign lane_valid = act_reg;
    assign lane_idx   = idx_reg[IdxW-1:0];
    assign lane_num   = cnt_reg;
    assign lane_last  = at_last;
    assign lane_scale = scale_reg;

endmodule

### rtl/cbdq_mul.sv
// ============================================================================
// cbdq_mul
// Three-stage bf16 x bf16 multiplier giving an exact fp32 product.
// ============================================================================
module cbdq_mul
    import cbdq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [15:0]       a,
    input  logic [15:0]       b,
    input  logic [LaneW-1:0]  in_lane,
    input  logic              in_last,
    output logic              out_valid,
    output out_item_t         out_item
);

    // Stage 1: classify, mantissa product, exponent sum
    logic              v1_reg;
    logic [LaneW-1:0]  lane1_reg;
    logic              last1_reg;
    logic              spec1_reg;
    logic [31:0]       specv1_reg;
    logic              sign1_reg;
    logic [15:0]       prod1_reg;
    logic [9:0]        exp1_reg;

    cls_t        ca, cb;
    logic        sgn;
    logic        spec;
    logic [31:0] specv;

    always_comb
    begin
        ca    = bf16_class(a);
        cb    = bf16_class(b);
        sgn   = a[15] ^ b[15];
        spec  = 1'b1;
        specv = {sgn, 31'd0};
        if (ca.nan)
            specv = {a, 16'd0} | 32'h0040_0000;
        else if (cb.nan)
            specv = {b, 16'd0} | 32'h0040_0000;
        else if ((ca.inf && cb.zero) || (cb.inf && ca.zero))
            specv = QNAN_F32;
        else if (ca.inf || cb.inf)
            specv = {sgn, 31'd0} | INF_F32;
        else if (ca.zero || cb.zero)
            specv = {sgn, 31'd0};
        else
            spec = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        lane1_reg  <= in_lane;
        last1_reg  <= in_last;
        spec1_reg  <= spec;
        specv1_reg <= specv;
        sign1_reg  <= sgn;
        prod1_reg  <= {8'd0, 1'b1, a[6:0]} * {8'd0, 1'b1, b[6:0]};
        exp1_reg   <= {2'd0, a[14:7]} + {2'd0, b[14:7]};
    end

    // Stage 2: normalize
    logic              v2_reg;
    logic [LaneW-1:0]  lane2_reg;
    logic              last2_reg;
    logic              spec2_reg;
    logic [31:0]       specv2_reg;
    logic              sign2_reg;
    logic [22:0]       mant2_reg;
    logic [9:0]        exp2_reg;

    always_ff @(posedge clk)
    begin
        lane2_reg  <= lane1_reg;
        last2_reg  <= last1_reg;
        spec2_reg  <= spec1_reg;
        specv2_reg <= specv1_reg;
        sign2_reg  <= sign1_reg;
        if (prod1_reg[15])
        begin
            mant2_reg <= {prod1_reg[14:0], 8'd0};
            exp2_reg  <= exp1_reg + 10'd1;
        end
        else
        begin
            mant2_reg <= {prod1_reg[13:0], 9'd0};
            exp2_reg  <= exp1_reg;
        end
    end

    // Stage 3: range check and packing (exp2 = biased result exponent + 127)
    logic              v3_reg;
    out_item_t         item3_reg;
    logic [31:0]       val;

    always_comb
    begin
        if (spec2_reg)
            val = specv2_reg;
        else if (exp2_reg >= 10'd382)
            val = {sign2_reg, 31'd0} | INF_F32;
        else if (exp2_reg <= 10'd127)
            val = {sign2_reg, 31'd0};
        else
            val = {sign2_reg, 8'(exp2_reg - 10'd127), mant2_reg};
    end

    always_ff @(posedge clk)
    begin
        item3_reg.value_bits <= val;
        item3_reg.lane       <= lane2_reg;
        item3_reg.last       <= last2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_item  = item3_reg;

endmodule

### rtl/codebook_dequant_3bit_bf16.sv
// ============================================================================
// codebook_dequant_3bit_bf16
// Dequantizes groups of sixteen 3-bit codebook indices to fp32 values.
// ============================================================================
// Usage:
//   Input: drive in_item (packed indices, fp32 scale) with start high; the
//   group transfers at the edge where start is high and busy is low.
//   Lanes are issued one per cycle; busy is high while lanes 0 to 14 issue,
//   so the next group can transfer in the cycle lane 15 issues and groups
//   follow with no gap.
//   Output: each result sits on result for exactly one cycle, marked by
//   result_valid; lane 0 first, last set on lane 15. The receiver cannot
//   stall; results must be taken when shown.
//   Path: lane 0 passes the issue register, the codebook read register and
//   three multiplier stages before it is on result; the later lanes follow
//   in order, one per cycle.
//   The group time is set by the one-lane-per-cycle issue counter.
//   Config: cfg_we writes codebook entry cfg_index (0..7) with cfg_data.
//   Write only while idle.
//   Reset: codebook returns to its default entries, pipeline empties.
// ============================================================================
module codebook_dequant_3bit_bf16
    import cbdq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  in_item_t            in_item,
    output logic                busy,
    output logic                result_valid,
    output out_item_t           result,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);

    logic [15:0] code_reg [NumCodes];

    // Codebook registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NumCodes; i++)
                code_reg[i] <= CODE_RESET[i];
        end
        else if (cfg_we)
        begin
            code_reg[cfg_index] <= cfg_data;
        end
    end

    logic              lv;
    logic [IdxW-1:0]   lidx;
    logic [LaneW-1:0]  lnum;
    logic              llast;
    logic [15:0]       lscale;

    cbdq_issue u_issue (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .in_item    (in_item),
        .busy       (busy),
        .lane_valid (lv),
        .lane_idx   (lidx),
        .lane_num   (lnum),
        .lane_last  (llast),
        .lane_scale (lscale)
    );

    // Codebook lookup stage
    logic              lk_v_reg;
    logic [15:0]       lk_code_reg;
    logic [15:0]       lk_scale_reg;
    logic [LaneW-1:0]  lk_lane_reg;
    logic              lk_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lk_v_reg <= 1'b0;
        else
            lk_v_reg <= lv;
    end

    always_ff @(posedge clk)
    begin
        lk_code_reg  <= code_reg[lidx];
        lk_scale_reg <= lscale;
        lk_lane_reg  <= lnum;
        lk_last_reg  <= llast;
    end

    cbdq_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lk_v_reg),
        .a         (lk_code_reg),
        .b         (lk_scale_reg),
        .in_lane   (lk_lane_reg),
        .in_last   (lk_last_reg),
        .out_valid (result_valid),
        .out_item  (result)
    );

endmodule

### rtl/cbdq_checker.sv
// ============================================================================
// cbdq_checker
// Port-level checks on the dequantizer's result sequence.
// ============================================================================
module cbdq_checker
    import cbdq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      busy,
    input  logic      result_valid,
    input  out_item_t result
);

    // A group transfer makes busy rise
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after start");

    // last marks exactly lane 15
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.last == (result.lane == 4'd15)))
        else $error("last flag mismatch");

    // Lanes within a group are consecutive
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |=> result_valid && result.lane == $past(result.lane) + 4'd1)
        else $error("lane sequence broken");

    // Lane 0 reaches result through the issue, lookup and multiplier registers
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##5 (result_valid && result.lane == 4'd0))
        else $error("lane 0 latency wrong");

endmodule

bind codebook_dequant_3bit_bf16 cbdq_checker u_cbdq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

### sim/tb_codebook_dequant_3bit_bf16.sv
// ============================================================================
// tb_codebook_dequant_3bit_bf16
// Self-checking bench for the 3-bit codebook dequantizer: groups are driven
// through the command port, each lane result is predicted from a local copy
// of the codebook and compared in order against the result strobe.
// ============================================================================
module tb_codebook_dequant_3bit_bf16
    import cbdq_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    logic                clk;
    logic                rst_n;
    logic                start;
    in_item_t            in_item;
    logic                busy;
    logic                result_valid;
    out_item_t           result;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;

    logic [15:0] codebook_copy [NumCodes];
    out_item_t   lane_queue [$];
    int          mismatches;
    int          groups_sent;
    int          lanes_checked;
    bit          allow_gaps;

    codebook_dequant_3bit_bf16 dut (.*);

    // 50 MHz clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // fp32 scale to bf16, nearest even, subnormals flushed
    function automatic logic [15:0] round_scale(input logic [31:0] f);
        logic [31:0] sum;
        sum = f + 32'h7FFF + {31'd0, f[16]};
        if (f[30:23] == 8'hFF && f[22:0] != 0)
            return f[31:16] | 16'h0040;
        if (f[30:23] == 8'd0)
            return {f[31], 15'd0};
        return sum[31:16];
    endfunction

    // Exact bf16 x bf16 product as fp32 bits
    function automatic logic [31:0] bf16_product(input logic [15:0] a,
                                                 input logic [15:0] b);
        logic [31:0] sgn;
        logic [15:0] prod;
        logic [31:0] mant;
        int          ex;
        bit          a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
        sgn    = {a[15] ^ b[15], 31'd0};
        a_nan  = (a[14:7] == 8'hFF) && (a[6:0] != 0);
        b_nan  = (b[14:7] == 8'hFF) && (b[6:0] != 0);
        a_inf  = (a[14:7] == 8'hFF) && (a[6:0] == 0);
        b_inf  = (b[14:7] == 8'hFF) && (b[6:0] == 0);
        a_zero = (a[14:7] == 8'd0);
        b_zero = (b[14:7] == 8'd0);
        if (a_nan)
            return {a, 16'd0} | 32'h0040_0000;
        if (b_nan)
            return {b, 16'd0} | 32'h0040_0000;
        if ((a_inf && b_zero) || (b_inf && a_zero))
            return QNAN_F32;
        if (a_inf || b_inf)
            return sgn | INF_F32;
        if (a_zero || b_zero)
            return sgn;
        prod = {8'd1, a[6:0]} * {8'd1, b[6:0]};
        ex   = int'(a[14:7]) + int'(b[14:7]) - 127;
        if (prod[15])
        begin
            ex++;
            mant = {8'd0, prod, 8'd0};
        end
        else
        begin
            mant = {7'd0, prod, 9'd0};
        end
        if (ex >= 255)
            return sgn | INF_F32;
        if (ex <= 0)
            return sgn;
        return sgn | (32'(ex) << 23) | {9'd0, mant[22:0]};
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, want);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && result_valid)
        begin
            if (lane_queue.size() == 0)
            begin
                report_mismatch("unexpected lane", {28'd0, result.lane}, 32'd0);
            end
            else
            begin
                want = lane_queue.pop_front();
                lanes_checked++;
                if (result.value_bits !== want.value_bits)
                    report_mismatch("value", result.value_bits, want.value_bits);
                if (result.lane !== want.lane)
                    report_mismatch("lane", {28'd0, result.lane}, {28'd0, want.lane});
                if (result.last !== want.last)
                    report_mismatch("last", {31'd0, result.last}, {31'd0, want.last});
            end
        end
    end

    // Send one group; expectations queued at the transfer edge.
    // start is left high on return; the next send may drop it or reuse it, and drain drops it.
    task automatic send_group(input logic [47:0] idx, input logic [31:0] scale);
        logic [15:0] s;
        out_item_t   o;
        if (allow_gaps && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        start   <= 1'b1;
        in_item <= '{packed_indices: idx, scale_bits: scale};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        s = round_scale(scale);
        for (int k = 0; k < GroupSize; k++)
        begin
            o.value_bits = bf16_product(codebook_copy[idx[3*k +: 3]], s);
            o.lane       = 4'(k);
            o.last       = (k == GroupSize - 1);
            lane_queue.push_back(o);
        end
        groups_sent++;
        @(negedge clk);
    endtask

    // Wait until all lanes are out, then let the pipe settle
    task automatic drain();
        start <= 1'b0;
        while (lane_queue.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Write a codebook entry and its local copy, then drop cfg_we and idle
    task automatic write_code(input int i, input logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= CfgIdxW'(i);
        cfg_data  <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (i < NumCodes)
            codebook_copy[i] = v;
        @(negedge clk);
    endtask

    function automatic logic [31:0] random_scale();
        case ($urandom_range(0, 9))
            0:       return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'd0, 23'($urandom)};
            1:       return {1'($urandom), 8'hFF, 23'($urandom)};
            2:       return {1'($urandom), 8'hFF, 23'd0};
            3:       return {1'($urandom), 8'($urandom_range(250, 254)), 23'($urandom)};
            4:       return {1'($urandom), 8'($urandom_range(1, 8)), 23'($urandom)};
            5:       return $urandom;
            default: return {1'($urandom), 8'($urandom_range(100, 150)), 23'($urandom)};
        endcase
    endfunction

    function automatic logic [15:0] random_code();
        case ($urandom_range(0, 7))
            0:       return {1'($urandom), 8'd0, 7'($urandom)};
            1:       return {1'($urandom), 8'hFF, 7'($urandom)};
            2:       return {1'($urandom), 8'hFF, 7'd0};
            3:       return 16'($urandom);
            default: return {1'($urandom), 8'($urandom_range(110, 140)), 7'($urandom)};
        endcase
    endfunction

    function automatic logic [47:0] random_indices();
        return {16'($urandom), $urandom};
    endfunction

    // Default codebook, field extremes and special scale values
    task automatic test_directed_default();
        send_group(48'h0, 32'h3F80_0000);
        send_group(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_group(48'hFAC6_88FA_C688, 32'h0000_0000);
        send_group(48'h0539_77FA_C688, 32'h8000_0000);
        send_group(48'h1234_5678_9ABC, 32'h007F_FFFF);
        send_group(48'hFAC6_88FA_C688, 32'h7F80_0000);
        send_group(48'hFAC6_88FA_C688, 32'hFF80_0000);
        send_group(48'hFAC6_88FA_C688, 32'h7F80_0001);
        send_group(48'hFAC6_88FA_C688, 32'h7F7F_FFFF);
        send_group(48'hFAC6_88FA_C688, 32'h3F80_8000);
        send_group(48'hFAC6_88FA_C688, 32'h3F81_8000);
        send_group(48'hFAC6_88FA_C688, 32'h0080_0000);
        send_group(48'hFAC6_88FA_C688, 32'h7F00_0000);
        drain();
    endtask

    // Codebook holding zero, inf, NaN, subnormal and big entries
    task automatic test_directed_specials();
        write_code(0, 16'h0000);
        write_code(1, 16'h8000);
        write_code(2, 16'h7F80);
        write_code(3, 16'hFF80);
        write_code(4, 16'h7F81);
        write_code(5, 16'h0045);
        write_code(6, 16'h7F7F);
        write_code(7, 16'h0080);
        send_group(48'hFAC6_88FA_C688, 32'h3F80_0000);
        send_group(48'hFAC6_88FA_C688, 32'h0000_0000);
        send_group(48'hFAC6_88FA_C688, 32'hFFC1_2345);
        send_group(48'hFAC6_88FA_C688, 32'h7F00_0000);
        send_group(48'hFAC6_88FA_C688, 32'h0080_0000);
        send_group(48'hFAC6_88FA_C688, 32'hFF80_0000);
        drain();
        write_code(0, 16'hFFFF);
        write_code(7, 16'hFFFF);
        send_group(48'h0, 32'hFF81_0000);
        send_group(48'hFFFF_FFFF_FFFF, 32'h3F80_0000);
        drain();
    endtask

    // Random groups: the first phase uses the default codebook, each later phase a random one
    task automatic test_random(input int phases, input int per_phase);
        for (int p = 0; p < phases; p++)
        begin
            for (int i = 0; i < NumCodes; i++)
                write_code(i, (p == 0) ? CODE_RESET[i] : random_code());
            for (int n = 0; n < per_phase; n++)
                send_group(random_indices(), random_scale());
            drain();
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        in_item    = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        mismatches = 0;
        allow_gaps = 1'b1;
        for (int i = 0; i < NumCodes; i++)
            codebook_copy[i] = CODE_RESET[i];
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed_default();
        test_directed_specials();
        test_random(6, 65);
        allow_gaps = 1'b0;
        test_random(1, 50);
        $display("Sent %0d groups, checked %0d lanes over default, special and random codebooks.",
                 groups_sent, lanes_checked);
        if (mismatches == 0)
            $display("tb_codebook_dequant_3bit_bf16 OK");
        else
            $display("tb_codebook_dequant_3bit_bf16 NOT OK");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5ms;
        $display("tb_codebook_dequant_3bit_bf16 NOT OK");
        $finish;
    end

endmodule

### filelist.f
rtl/cbdq_pkg.sv
rtl/cbdq_issue.sv
rtl/cbdq_mul.sv
rtl/codebook_dequant_3bit_bf16.sv
rtl/cbdq_checker.sv
sim/tb_codebook_dequant_3bit_bf16.sv
